// ----- rtl/buffer_pool_frame_manager_core_macros.svh -----
// assertion macros shared by the frame manager rtl
`ifndef BUFFER_POOL_FRAME_MANAGER_CORE_MACROS_SVH
`define BUFFER_POOL_FRAME_MANAGER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define BPFM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BPFM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bpfm_pkg.sv -----
// shared types and constants of the buffer pool frame manager
`default_nettype none
package bpfm_pkg;

  localparam int POOL_FRAMES_DEF = 64;
  localparam int PIN_BITS_DEF    = 16;

  localparam int TAG_W       = 32;
  localparam int FRAME_W     = 6;
  localparam int KIND_W      = 3;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_FETCH  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_UNPIN  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NEW    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd4;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_UPD,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    LRU_NONE,
    LRU_REMOVE,
    LRU_INSERT
  } lru_op_t;

  typedef struct packed {
    logic               zero_fill;
    logic               read_in;
    logic [TAG_W-1:0]   write_back_page;
    logic               write_back;
    logic               hit;
    logic [FRAME_W-1:0] frame;
    logic               ok;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/bpfm_frame_ram.sv -----
// per-frame record memory, one write and one registered read port
`default_nettype none
module bpfm_frame_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ----- rtl/bpfm_free_queue.sv -----
// circular free-frame queue held in a memory, with head and fill count
`default_nettype none
module bpfm_free_queue #(
  parameter int N  = 64,
  parameter int IW = 6,
  parameter int CW = 7
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          init_we,
  input  wire logic [IW-1:0] init_idx,
  input  wire logic          pop,
  input  wire logic          push,
  input  wire logic [IW-1:0] push_frame,
  output logic      [IW-1:0] head_frame,
  output logic      [CW-1:0] count
);

  localparam logic [CW:0]   N_W    = (CW+1)'(N);
  localparam logic [IW-1:0] LAST_I = IW'(N - 1);

  logic [IW-1:0] mem [N];
  logic [IW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW:0]   tail_sum;
  logic [IW-1:0] tail;
  logic          wr_en;
  logic [IW-1:0] wr_addr, wr_data;

  // tail position modulo the depth
  always_comb begin
    tail_sum = (CW+1)'(head_r) + (CW+1)'(count_r);
    if (tail_sum >= N_W) begin
      tail = IW'(tail_sum - N_W);
    end else begin
      tail = IW'(tail_sum);
    end
  end

  // write port select: init sweep or push
  always_comb begin
    wr_en   = init_we | push;
    wr_addr = init_we ? init_idx : tail;
    wr_data = init_we ? init_idx : push_frame;
  end

  // head and count updates
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (pop) begin
      head_nxt  = (head_r == LAST_I) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end else if (push) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= CW'(N);
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // memory write and registered head read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    head_frame <= mem[head_r];
  end

  assign count = count_r;

endmodule
`default_nettype wire

// ----- rtl/buffer_pool_frame_manager_core.sv -----
// Frame manager of a page buffer: tag lookup, free queue and LRU victim choice.
//
// Input channel in_*: one request item per handshake; in_tuser carries the
// kind (fetch, unpin, flush, new page, delete), in_tdata the page id and the
// dirty mark. Output channel out_*: one result item per request, in order.
// All frame state (tag, valid, pin count, dirty, LRU membership and rank)
// lives in one record memory; free frames live in a circular queue memory.
// A request takes a lookup pass over the record memory to find the page and
// the LRU victim, a decision step, and, when any frame changes, an update
// pass that rewrites the target frame and the LRU ranks, then an output step.
// Both passes use the single read port of the record memory; the next item
// is accepted only once the result of the last one has been loaded into the
// output register, so requests do not overlap.
// The next request is accepted while a finished result still waits in the
// output register; a stalled receiver holds that result until taken.
// After reset the block sweeps both memories before in_tready rises.
`default_nettype none
module buffer_pool_frame_manager_core #(
  parameter int POOL_FRAMES = bpfm_pkg::POOL_FRAMES_DEF,
  parameter int PIN_BITS    = bpfm_pkg::PIN_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // page_id [31:0], mark_dirty [32], zero [39:33]
  input  wire logic [bpfm_pkg::IN_TDATA_W-1:0]  in_tdata,
  // kind [2:0]
  input  wire logic [bpfm_pkg::KIND_W-1:0]      in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // ok [0], frame [6:1], hit [7], write_back [8], write_back_page [40:9],
  // read_in [41], zero_fill [42], zero [47:43]
  output logic      [bpfm_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import bpfm_pkg::*;
  `include "buffer_pool_frame_manager_core_macros.svh"

  localparam int IW = $clog2(POOL_FRAMES);
  localparam int CW = $clog2(POOL_FRAMES + 1);
  localparam int AW = IW;
  localparam int RW = TAG_W + 3 + PIN_BITS + AW;
  // record layout from the lowest bit: age, pin, member, dirty, valid, tag
  localparam int PIN_LO   = AW;
  localparam int MEM_B    = AW + PIN_BITS;
  localparam int DIRTY_B  = MEM_B + 1;
  localparam int VALID_B  = MEM_B + 2;
  localparam int TAG_LO   = MEM_B + 3;
  localparam logic [CW-1:0]       FRAMES_C = CW'(POOL_FRAMES);
  localparam logic [CW-1:0]       LAST_C   = CW'(POOL_FRAMES - 1);
  localparam logic [PIN_BITS-1:0] PIN_MAX  = '1;

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          rd_vld_r;
  logic [IW-1:0] rd_idx_r;
  logic [KIND_W-1:0] kind_r;
  logic [TAG_W-1:0]  page_r;
  logic              mark_r;

  // lookup results
  logic                hit_r;
  logic [IW-1:0]       hit_idx_r;
  logic [PIN_BITS-1:0] hit_pin_r;
  logic                hit_dirty_r, hit_mem_r;
  logic [AW-1:0]       hit_age_r;
  logic                vic_r;
  logic [IW-1:0]       vic_idx_r;
  logic [AW-1:0]       vic_age_r;
  logic                vic_valid_r, vic_dirty_r;
  logic [TAG_W-1:0]    vic_tag_r;

  // update plan
  logic          tgt_wr_r;
  logic          tgt_push_r;
  logic [IW-1:0] tgt_idx_r;
  logic [RW-1:0] tgt_rec_r;
  lru_op_t       lru_op_r;
  logic [AW-1:0] ref_age_r;
  res_t          res_r;
  res_t          out_r;
  logic          out_valid_r;

  // decision outputs
  logic          dec_wr;
  logic [IW-1:0] dec_idx;
  logic [RW-1:0] dec_rec;
  lru_op_t       dec_op;
  logic [AW-1:0] dec_ref;
  res_t          dec_res;
  logic          dec_pop, dec_push;

  // memory ports and control
  logic          fm_we;
  logic [IW-1:0] fm_wr_addr, fm_rd_addr;
  logic [RW-1:0] fm_wr_data, fm_rd_data;
  logic          issue, fq_init, fq_pop, fq_push, load_out, scan_done;
  logic [IW-1:0] fq_head;
  logic [CW-1:0] fq_count;
  logic [RW-1:0] upd_rec;

  // unpacked fields of the record being read
  logic [TAG_W-1:0]    rd_tag;
  logic                rd_valid, rd_dirty, rd_mem;
  logic [PIN_BITS-1:0] rd_pin;
  logic [AW-1:0]       rd_age;

  assign rd_tag   = fm_rd_data[TAG_LO +: TAG_W];
  assign rd_valid = fm_rd_data[VALID_B];
  assign rd_dirty = fm_rd_data[DIRTY_B];
  assign rd_mem   = fm_rd_data[MEM_B];
  assign rd_pin   = fm_rd_data[PIN_LO +: PIN_BITS];
  assign rd_age   = fm_rd_data[AW-1:0];

  bpfm_frame_ram #(
    .DEPTH(POOL_FRAMES), .AW(IW), .DW(RW)
  ) u_frame_ram (
    .clk(clk), .we(fm_we), .wr_addr(fm_wr_addr), .wr_data(fm_wr_data),
    .rd_addr(fm_rd_addr), .rd_data(fm_rd_data)
  );

  bpfm_free_queue #(
    .N(POOL_FRAMES), .IW(IW), .CW(CW)
  ) u_free_queue (
    .clk(clk), .rst_n(rst_n), .init_we(fq_init), .init_idx(cnt_r[IW-1:0]),
    .pop(fq_pop), .push(fq_push), .push_frame(tgt_idx_r),
    .head_frame(fq_head), .count(fq_count)
  );

  assign scan_done = (cnt_r == FRAMES_C) && !rd_vld_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT:   if (cnt_r == LAST_C) state_nxt = S_IDLE;
      S_IDLE:   if (in_tvalid) state_nxt = S_SCAN;
      S_SCAN:   if (scan_done) state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = dec_wr ? S_UPD : S_OUT;
      S_UPD:    if (scan_done) state_nxt = S_OUT;
      S_OUT:    if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default:  state_nxt = S_INIT;
    endcase
  end

  // rmw of one record during the update pass
  always_comb begin
    upd_rec = fm_rd_data;
    if (rd_idx_r == tgt_idx_r) begin
      upd_rec = tgt_rec_r;
    end else if (rd_mem && lru_op_r == LRU_REMOVE && rd_age > ref_age_r) begin
      upd_rec[AW-1:0] = rd_age - 1'b1;
    end else if (rd_mem && lru_op_r == LRU_INSERT) begin
      upd_rec[AW-1:0] = rd_age + 1'b1;
    end
  end

  // control outputs
  always_comb begin
    in_tready  = (state_r == S_IDLE);
    issue      = ((state_r == S_SCAN) || (state_r == S_UPD)) && (cnt_r != FRAMES_C);
    fm_rd_addr = cnt_r[IW-1:0];
    fq_init    = (state_r == S_INIT);
    fm_we      = 1'b0;
    fm_wr_addr = rd_idx_r;
    fm_wr_data = upd_rec;
    if (state_r == S_INIT) begin
      fm_we      = 1'b1;
      fm_wr_addr = cnt_r[IW-1:0];
      fm_wr_data = '0;
    end else if (state_r == S_UPD && rd_vld_r) begin
      fm_we = 1'b1;
    end
    fq_pop   = (state_r == S_DECIDE) && dec_pop;
    fq_push  = (state_r == S_UPD) && (cnt_r == '0) && tgt_push_r;
    load_out = (state_r == S_OUT) && (!out_valid_r || out_tready);
  end

  // decision on the lookup results
  always_comb begin
    logic [TAG_W-1:0]    r_tag;
    logic                r_valid, r_dirty, r_mem, take;
    logic [PIN_BITS-1:0] r_pin, pin_dec;
    logic [AW-1:0]       r_age;
    r_tag    = page_r;
    r_valid  = 1'b1;
    r_dirty  = hit_dirty_r;
    r_mem    = hit_mem_r;
    r_pin    = hit_pin_r;
    r_age    = hit_age_r;
    take     = 1'b0;
    pin_dec  = hit_pin_r - 1'b1;
    dec_wr   = 1'b0;
    dec_idx  = hit_idx_r;
    dec_op   = LRU_NONE;
    dec_ref  = hit_age_r;
    dec_res  = '0;
    dec_pop  = 1'b0;
    dec_push = 1'b0;
    if (hit_r && kind_r <= KIND_DELETE) begin
      dec_res.frame = FRAME_W'(hit_idx_r);
      dec_res.hit   = 1'b1;
    end
    case (kind_r)
      KIND_FETCH, KIND_NEW: begin
        if (hit_r) begin
          if (kind_r == KIND_FETCH) begin
            if (hit_pin_r != PIN_MAX) r_pin = hit_pin_r + 1'b1;
            r_mem      = 1'b0;
            r_age      = '0;
            dec_op     = hit_mem_r ? LRU_REMOVE : LRU_NONE;
            dec_wr     = 1'b1;
            dec_res.ok = 1'b1;
          end
        end else begin
          if (fq_count != '0) begin
            dec_idx = fq_head;
            dec_pop = 1'b1;
            take    = 1'b1;
          end else if (vic_r) begin
            dec_idx = vic_idx_r;
            dec_op  = LRU_REMOVE;
            dec_ref = vic_age_r;
            take    = 1'b1;
            if (vic_valid_r && vic_dirty_r) begin
              dec_res.write_back      = 1'b1;
              dec_res.write_back_page = vic_tag_r;
            end
          end
          if (take) begin
            r_dirty           = 1'b0;
            r_mem             = 1'b0;
            r_pin             = PIN_BITS'(1);
            r_age             = '0;
            dec_wr            = 1'b1;
            dec_res.ok        = 1'b1;
            dec_res.frame     = FRAME_W'(dec_idx);
            dec_res.read_in   = (kind_r == KIND_FETCH);
            dec_res.zero_fill = (kind_r == KIND_NEW);
          end
        end
      end
      KIND_UNPIN: begin
        if (hit_r && hit_pin_r != '0) begin
          r_pin   = pin_dec;
          r_dirty = hit_dirty_r | mark_r;
          if (pin_dec == '0) begin
            if (!hit_mem_r) begin
              r_mem  = 1'b1;
              r_age  = '0;
              dec_op = LRU_INSERT;
            end
            if (r_dirty) begin
              dec_res.write_back      = 1'b1;
              dec_res.write_back_page = page_r;
            end
          end
          dec_wr     = 1'b1;
          dec_res.ok = 1'b1;
        end
      end
      KIND_FLUSH: begin
        if (hit_r) begin
          if (hit_dirty_r) begin
            dec_res.write_back      = 1'b1;
            dec_res.write_back_page = page_r;
          end
          r_dirty    = 1'b0;
          dec_wr     = 1'b1;
          dec_res.ok = 1'b1;
        end
      end
      KIND_DELETE: begin
        if (!hit_r) begin
          dec_res.ok = 1'b1;
        end else if (hit_pin_r == '0) begin
          r_valid    = 1'b0;
          r_dirty    = 1'b0;
          r_mem      = 1'b0;
          r_age      = '0;
          dec_op     = hit_mem_r ? LRU_REMOVE : LRU_NONE;
          dec_push   = (fq_count != FRAMES_C);
          dec_wr     = 1'b1;
          dec_res.ok = 1'b1;
        end
      end
      default: dec_res = '0;
    endcase
    dec_rec = {r_tag, r_valid, r_dirty, r_mem, r_pin, r_age};
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rd_vld_r <= issue;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // pass counter
  always_comb begin
    cnt_nxt = cnt_r;
    case (state_r)
      S_INIT:   cnt_nxt = cnt_r + 1'b1;
      S_IDLE:   cnt_nxt = '0;
      S_SCAN:   if (issue) cnt_nxt = cnt_r + 1'b1;
      S_DECIDE: cnt_nxt = '0;
      S_UPD:    if (issue) cnt_nxt = cnt_r + 1'b1;
      S_OUT:    cnt_nxt = '0;
      default:  cnt_nxt = '0;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r[IW-1:0];
    if (in_tready && in_tvalid) begin
      kind_r <= in_tuser;
      page_r <= in_tdata[TAG_W-1:0];
      mark_r <= in_tdata[TAG_W];
      hit_r  <= 1'b0;
      vic_r  <= 1'b0;
    end
    // lookup and victim search over the scan pass
    if (state_r == S_SCAN && rd_vld_r) begin
      if (!hit_r && rd_valid && rd_tag == page_r) begin
        hit_r       <= 1'b1;
        hit_idx_r   <= rd_idx_r;
        hit_pin_r   <= rd_pin;
        hit_dirty_r <= rd_dirty;
        hit_mem_r   <= rd_mem;
        hit_age_r   <= rd_age;
      end
      if (rd_mem && (!vic_r || rd_age > vic_age_r)) begin
        vic_r       <= 1'b1;
        vic_idx_r   <= rd_idx_r;
        vic_age_r   <= rd_age;
        vic_valid_r <= rd_valid;
        vic_dirty_r <= rd_dirty;
        vic_tag_r   <= rd_tag;
      end
    end
    if (state_r == S_DECIDE) begin
      tgt_wr_r   <= dec_wr;
      tgt_push_r <= dec_push;
      tgt_idx_r  <= dec_idx;
      tgt_rec_r  <= dec_rec;
      lru_op_r   <= dec_op;
      ref_age_r  <= dec_ref;
      res_r      <= dec_res;
    end
    if (load_out) begin
      out_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - $bits(res_t)){1'b0}}, out_r};

  `BPFM_ASSERT_IMP(a_free_count_range, 1'b1, fq_count <= FRAMES_C,
                   "free count above pool size")
  `BPFM_ASSERT_NXT(a_accept_starts_scan, in_tvalid && in_tready, state_r == S_SCAN,
                   "accepted item did not start a lookup")
  `BPFM_ASSERT_IMP(a_readin_is_miss, out_tvalid && out_r.read_in,
                   out_r.ok && !out_r.hit && !out_r.zero_fill,
                   "read-in reported for a resident page")
  `BPFM_ASSERT_IMP(a_update_has_plan, state_r == S_UPD, tgt_wr_r,
                   "update pass without a frame write")

endmodule
`default_nettype wire
